@@ design/fhdf_pkg.sv @@
// Shared types, constants and the FNV-1a fold function for the hash dedup filter.
package fhdf_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_line_part;
		logic       has_byte;
		logic       record_end;
	} item_beat_t;

	typedef struct packed {
		logic [31:0] hash_value;
		logic        is_duplicate;
	} result_beat_t;

	// Control broadcast along the row of ring cells.
	typedef struct packed {
		logic [31:0] key;
		logic        shift;
	} cell_ctl_t;

	function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

endpackage

@@ design/fhdf_hash_acc.sv @@
// Running FNV-1a accumulator with capped line-byte count.
module fhdf_hash_acc #(
	parameter int LINE_CAP = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  fhdf_pkg::item_beat_t beat,
	output logic [31:0]         hash_next
);
	import fhdf_pkg::*;

	localparam int CNT_W = $clog2(LINE_CAP + 1);

	logic [31:0]      hash_q;
	logic [CNT_W-1:0] cnt_q;
	logic             fold;

	assign fold = beat.has_byte && (!beat.is_line_part || (cnt_q < CNT_W'(LINE_CAP)));
	assign hash_next = fold ? fold_byte(hash_q, beat.data_byte) : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
			cnt_q  <= '0;
		end else if (accept) begin
			if (beat.record_end) begin
				hash_q <= FNV_BASIS;
				cnt_q  <= '0;
			end else begin
				hash_q <= hash_next;
				if (fold && beat.is_line_part) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

@@ design/fhdf_ring_cell.sv @@
// One ring cell: holds a recent hash, shifts on insert, chains the hit flag.
module fhdf_ring_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fhdf_pkg::cell_ctl_t ctl,
	input  logic [31:0]         entry_in,
	input  logic                hit_in,
	output logic [31:0]         entry_out,
	output logic                hit_out
);
	import fhdf_pkg::*;

	logic [31:0] entry_q;
	logic        hit_q;

	assign entry_out = entry_q;
	assign hit_out   = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			hit_q <= hit_in | (entry_q == ctl.key);
			if (ctl.shift) begin
				entry_q <= entry_in;
			end
		end
	end

endmodule

@@ design/fnv1a_hash_dedup_filter.sv @@
// Top level: FNV-1a record hash with a row of recent-hash cells for dedup.
//
// Items arrive on the item channel (valid/ready), one byte per beat, tagged as
// name or line bytes; line bytes past LINE_CAP are dropped. Non-final beats
// are taken one per cycle. The beat with record_end closes the record: its
// hash walks the hit flag down the row of RING_DEPTH cells, one cell per
// cycle, so item_ready is low through ST_SEARCH and ST_DONE after it. The
// result (hash, duplicate flag) is then registered onto the result channel.
// A hash that is not a duplicate is pushed into the first cell and the
// oldest falls off the end of the row.
// The result sits in an output register: more bytes of the next record are
// taken while it waits. If the receiver still stalls when the next lookup
// finishes, that lookup holds until the register frees.
// Reset clears all cells to zero, so a zero hash first reads as a duplicate,
// and restarts the running hash at the FNV offset basis.
module fnv1a_hash_dedup_filter #(
	parameter int RING_DEPTH = 64,
	parameter int LINE_CAP   = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  fhdf_pkg::item_beat_t   item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output fhdf_pkg::result_beat_t result
);
	import fhdf_pkg::*;

	localparam int CNT_W = $clog2(RING_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]     key_q;
	logic            shift;
	logic            load_result;
	logic            accept;
	logic [31:0]     hash_next;
	result_beat_t    result_q;
	logic            result_valid_q;
	cell_ctl_t       ctl;

	logic [31:0] entry [RING_DEPTH];
	logic        hit   [RING_DEPTH];

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign load_result = (state_q == ST_DONE) && (!result_valid_q || result_ready);
	assign shift       = load_result && !hit[RING_DEPTH-1];
	assign ctl         = '{key: key_q, shift: shift};

	fhdf_hash_acc #(
		.LINE_CAP(LINE_CAP)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.beat     (item),
		.hash_next(hash_next)
	);

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			fhdf_ring_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.entry_in (key_q),
				.hit_in   (1'b0),
				.entry_out(entry[i]),
				.hit_out  (hit[i])
			);
		end else begin : g_rest
			fhdf_ring_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.entry_in (entry[i-1]),
				.hit_in   (hit[i-1]),
				.entry_out(entry[i]),
				.hit_out  (hit[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			key_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.record_end) begin
						key_q   <= hash_next;
						cnt_q   <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(RING_DEPTH - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_result) begin
						result_q.hash_value   <= key_q;
						result_q.is_duplicate <= hit[RING_DEPTH-1];
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/sv/fnv1a_hash_dedup_filter_tb.sv @@
// Testbench for the FNV-1a record hash and recent-hash dedup filter.
module fnv1a_hash_dedup_filter_tb;

	import fhdf_pkg::*;

	localparam int RING_DEPTH     = 64;
	localparam int LINE_CAP       = 64;
	localparam int ITEM_TARGET    = 1750;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 100;
	localparam int TBL_SLOTS      = 131072;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_beat_t item_beat = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_beat_t result_beat;

	fnv1a_hash_dedup_filter #(
		.RING_DEPTH(RING_DEPTH),
		.LINE_CAP  (LINE_CAP)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item_beat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result_beat)
	);

	always #6 clk = ~clk;

	item_beat_t   pending_items[$];
	item_beat_t   record_buf[$];
	item_beat_t   saved_beats[$];
	int           saved_start[$];
	int           saved_len[$];
	result_beat_t expected_results[$];
	result_beat_t want;

	logic [31:0] run_hash = FNV_BASIS;
	int          line_count = 0;
	logic [31:0] seen_ring [RING_DEPTH];
	int          ring_pos = 0;

	int items_total = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int dups_seen = 0;
	int errors = 0;
	int stall_cycles = 0;

	logic [31:0] fwd_hash [TBL_SLOTS];
	logic [15:0] fwd_pair [TBL_SLOTS];
	bit          fwd_used [TBL_SLOTS];
	logic [7:0]  zero_key [5];
	bit          zero_key_found;

	function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
		return (h ^ {24'd0, b}) * FNV_PRIME;
	endfunction

	task automatic report(string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	// Fold one accepted beat and queue the result it closes, if any.
	task automatic hash_beat(item_beat_t b);
		bit dup;
		result_beat_t r;
		dup = 1'b0;
		if (b.has_byte) begin
			if (!b.is_line_part) begin
				run_hash = fnv_step(run_hash, b.data_byte);
			end else if (line_count < LINE_CAP) begin
				run_hash = fnv_step(run_hash, b.data_byte);
				line_count++;
			end
		end
		if (b.record_end) begin
			for (int i = 0; i < RING_DEPTH; i++)
				if (seen_ring[i] == run_hash)
					dup = 1'b1;
			if (!dup) begin
				seen_ring[ring_pos] = run_hash;
				ring_pos = (ring_pos + 1) % RING_DEPTH;
			end
			r.hash_value = run_hash;
			r.is_duplicate = dup;
			expected_results.push_back(r);
			run_hash = FNV_BASIS;
			line_count = 0;
		end
	endtask

	// Meet in the middle: two bytes forward from the basis, three back from zero.
	task automatic find_zero_key();
		logic [31:0] pinv;
		logic [31:0] h;
		int slot;
		pinv = FNV_PRIME;
		repeat (5) pinv = pinv * (32'd2 - FNV_PRIME * pinv);
		for (int b1 = 0; b1 < 256; b1++) begin
			for (int b2 = 0; b2 < 256; b2++) begin
				h = fnv_step(fnv_step(FNV_BASIS, b1[7:0]), b2[7:0]);
				slot = int'(h[31:15]);
				while (fwd_used[slot])
					slot = (slot + 1) % TBL_SLOTS;
				fwd_used[slot] = 1'b1;
				fwd_hash[slot] = h;
				fwd_pair[slot] = {b1[7:0], b2[7:0]};
			end
		end
		zero_key_found = 1'b0;
		for (int b5 = 0; b5 < 256 && !zero_key_found; b5++) begin
			for (int b4 = 0; b4 < 256 && !zero_key_found; b4++) begin
				for (int b3 = 0; b3 < 256 && !zero_key_found; b3++) begin
					h = (((b5 * pinv) ^ b4) * pinv) ^ b3;
					slot = int'(h[31:15]);
					while (fwd_used[slot] && !zero_key_found) begin
						if (fwd_hash[slot] == h) begin
							zero_key_found = 1'b1;
							zero_key[0] = fwd_pair[slot][15:8];
							zero_key[1] = fwd_pair[slot][7:0];
							zero_key[2] = b3[7:0];
							zero_key[3] = b4[7:0];
							zero_key[4] = b5[7:0];
						end
						slot = (slot + 1) % TBL_SLOTS;
					end
				end
			end
		end
	endtask

	task automatic add_beat(logic [7:0] data, bit line, bit has, bit last);
		item_beat_t b;
		b.data_byte = data;
		b.is_line_part = line;
		b.has_byte = has;
		b.record_end = last;
		record_buf.push_back(b);
	endtask

	task automatic commit_record();
		saved_start.push_back(saved_beats.size());
		saved_len.push_back(record_buf.size());
		foreach (record_buf[k]) begin
			pending_items.push_back(record_buf[k]);
			saved_beats.push_back(record_buf[k]);
		end
		record_buf.delete();
	endtask

	task automatic random_record();
		int kind;
		int n;
		int idx;
		kind = $urandom_range(0, 99);
		if (kind < 15 && saved_start.size() > 0) begin
			// replay an earlier record: a duplicate unless it has aged out of the ring
			idx = $urandom_range(0, saved_start.size() - 1);
			for (int k = 0; k < saved_len[idx]; k++)
				pending_items.push_back(saved_beats[saved_start[idx] + k]);
		end else if (kind < 22) begin
			n = $urandom_range(66, 90);
			for (int k = 0; k < n; k++)
				add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0,
					$urandom_range(0, 15) != 0, k == n - 1);
			commit_record();
		end else begin
			n = $urandom_range(1, 12);
			for (int k = 0; k < n; k++)
				add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 7) != 0, k == n - 1);
			commit_record();
		end
	endtask

	function automatic int idle_pct(bit sender);
		if (items_accepted < items_total / 3)
			return sender ? 13 : 48;
		else if (items_accepted < 2 * items_total / 3)
			return sender ? 48 : 13;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_beat <= '0;
		end else begin
			if (item_valid && item_ready) begin
				hash_beat(item_beat);
				items_accepted++;
			end
			if (!item_valid || item_ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
					item_valid <= 1'b1;
					item_beat <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected result: hash %h dup %0b",
						result_beat.hash_value, result_beat.is_duplicate));
				end else begin
					want = expected_results.pop_front();
					if (result_beat.hash_value !== want.hash_value)
						report($sformatf("hash_value expected %h actual %h",
							want.hash_value, result_beat.hash_value));
					if (result_beat.is_duplicate !== want.is_duplicate)
						report($sformatf("is_duplicate expected %0b actual %0b (hash %h)",
							want.is_duplicate, result_beat.is_duplicate, want.hash_value));
					results_checked++;
					if (want.is_duplicate)
						dups_seen++;
				end
			end
			result_ready <= $urandom_range(0, 99) >= idle_pct(1'b0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
				$display("fnv1a_hash_dedup_filter_tb failed");
				$finish;
			end
		end
	end

	initial begin
		foreach (seen_ring[i])
			seen_ring[i] = '0;
		find_zero_key();

		// empty record, then again as a duplicate
		add_beat(8'h5A, 1'b0, 1'b0, 1'b1);
		commit_record();
		add_beat(8'hC3, 1'b1, 1'b0, 1'b1);
		commit_record();
		// byte on the closing beat
		add_beat(8'h00, 1'b0, 1'b1, 1'b1);
		commit_record();
		// ignored data byte, empty closing beat
		add_beat(8'hFF, 1'b1, 1'b1, 1'b0);
		add_beat(8'hA5, 1'b1, 1'b0, 1'b0);
		add_beat(8'h3C, 1'b0, 1'b0, 1'b1);
		commit_record();
		// zero hash hits the cleared ring
		if (zero_key_found) begin
			for (int k = 0; k < 5; k++)
				add_beat(zero_key[k], 1'b0, 1'b1, k == 4);
			commit_record();
		end
		// name bytes after line bytes
		add_beat(8'h80, 1'b1, 1'b1, 1'b0);
		add_beat(8'h01, 1'b1, 1'b1, 1'b0);
		add_beat(8'hFF, 1'b0, 1'b1, 1'b0);
		add_beat(8'hFE, 1'b1, 1'b1, 1'b1);
		commit_record();

		while (pending_items.size() < ITEM_TARGET)
			random_record();
		items_total = pending_items.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (RING_DEPTH + 16) @(posedge clk);

		$display("%0d item beats sent, %0d hash results checked, %0d of them duplicates",
			items_accepted, results_checked, dups_seen);
		$display("zero-hash record %s, %0d mismatches",
			zero_key_found ? "included" : "not found", errors);
		if (errors == 0)
			$display("fnv1a_hash_dedup_filter_tb passed");
		else
			$display("fnv1a_hash_dedup_filter_tb failed");
		$finish;
	end

endmodule
